@@ rtl/core/imghalve_pkg.sv @@
// package for the 2x2 image halving block
// sizes, register indexes and shared types; no dependencies
package imghalve_pkg;

  localparam int MAX_ROW_PIXELS = 1024;
  localparam int MAX_ROWS       = 4096;
  localparam int PIX_W          = 8;
  localparam int PIXEL_W        = 4 * PIX_W;
  localparam int NUM_LANES      = 4;
  localparam int COL_W          = $clog2(MAX_ROW_PIXELS);
  localparam int ROW_W          = $clog2(MAX_ROWS);
  localparam int WIDTH_W        = COL_W + 1;
  localparam int HEIGHT_W       = ROW_W + 1;
  localparam int CFG_DATA_W     = HEIGHT_W;
  localparam int CFG_IDX_W      = 2;
  localparam int PAIR_DEPTH     = MAX_ROW_PIXELS / 2;
  localparam int PAIR_AW        = $clog2(PAIR_DEPTH);
  localparam int PAIR_W         = 2 * PIXEL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USE_MAXIMUM   = 2'd0,
    CFG_FOUR_CHANNEL  = 2'd1,
    CFG_SOURCE_WIDTH  = 2'd2,
    CFG_SOURCE_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef logic [PIX_W-1:0] chan_t;

  typedef struct packed {
    logic use_max;
    logic four_ch;
  } mode_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } pos_flags_t;

endpackage

@@ rtl/core/imghalve_ram.sv @@
// generic single-write, single-read RAM with registered read data
// no package dependency
module imghalve_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/imghalve_lane.sv @@
// one channel lane: max of four, pairwise rounded average or rounded gray mean of four
// depends on imghalve_pkg
module imghalve_lane (
  input  imghalve_pkg::chan_t  p00,
  input  imghalve_pkg::chan_t  p01,
  input  imghalve_pkg::chan_t  p10,
  input  imghalve_pkg::chan_t  p11,
  input  imghalve_pkg::mode_t  mode,
  output imghalve_pkg::chan_t  res
);
  import imghalve_pkg::*;

  chan_t              max_top;
  chan_t              max_bot;
  chan_t              max_all;
  logic [PIX_W:0]     sum_top;
  logic [PIX_W:0]     sum_bot;
  chan_t              avg_top;
  chan_t              avg_bot;
  logic [PIX_W:0]     sum_pair;
  chan_t              avg_pair;
  logic [PIX_W+1:0]   sum_four;

  always_comb begin
    max_top  = (p00 > p01) ? p00 : p01;
    max_bot  = (p10 > p11) ? p10 : p11;
    max_all  = (max_top > max_bot) ? max_top : max_bot;

    sum_top  = {1'b0, p00} + {1'b0, p01} + (PIX_W+1)'(1);
    sum_bot  = {1'b0, p10} + {1'b0, p11} + (PIX_W+1)'(1);
    avg_top  = sum_top[PIX_W:1];
    avg_bot  = sum_bot[PIX_W:1];
    sum_pair = {1'b0, avg_top} + {1'b0, avg_bot} + (PIX_W+1)'(1);
    avg_pair = sum_pair[PIX_W:1];

    // gray: (a+b+c+d+2)/4
    sum_four = {2'b00, p00} + {2'b00, p01} + {2'b00, p10} + {2'b00, p11}
             + (PIX_W+2)'(2);

    priority if (mode.use_max) begin
      res = max_all;
    end else if (mode.four_ch) begin
      res = avg_pair;
    end else begin
      res = sum_four[PIX_W+1:2];
    end
  end

endmodule

@@ rtl/core/imghalve_merge.sv @@
// merging stage: gathers the lane results into the output register
// depends on imghalve_pkg
module imghalve_merge (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   load,
  input  imghalve_pkg::chan_t [imghalve_pkg::NUM_LANES-1:0] lane_res,
  input  logic                                   four_ch,
  input  imghalve_pkg::pos_flags_t               flags,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output imghalve_pkg::chan_t [imghalve_pkg::NUM_LANES-1:0] res,
  output imghalve_pkg::pos_flags_t               res_flags
);
  import imghalve_pkg::*;

  logic                        valid_r;
  logic                        valid_nxt;
  chan_t [NUM_LANES-1:0]       res_r;
  chan_t [NUM_LANES-1:0]       res_nxt;
  pos_flags_t                  flags_r;

  always_comb begin
    res_nxt = lane_res;
    // grayscale leaves channels 1..3 at zero
    for (int k = 1; k < NUM_LANES; k++) begin
      if (!four_ch) begin
        res_nxt[k] = '0;
      end
    end
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r   <= res_nxt;
      flags_r <= flags;
    end
  end

  assign out_valid = valid_r;
  assign res       = res_r;
  assign res_flags = flags_r;

endmodule

@@ rtl/core/image_halve_2x2_avg_or_max.sv @@
// top level of the 2x2 image halving block (average or maximum)
// depends on imghalve_pkg, imghalve_ram, imghalve_lane, imghalve_merge
//
//   channel   | handshake           | payload
//   ----------+---------------------+--------------------------------------------
//   in_       | in_valid / in_stall | in_chan_r, in_chan_g, in_chan_b, in_chan_a
//   out_      | out_valid/out_stall | out_res_r..a, out_row_end, out_frame_end
//   cfg_      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one source pixel accepted per clock while in_stall is low; a reduced pixel
// shows up on out_ in the cycle after its block's bottom-right item is accepted
// the row store keeps even rows as pixel pairs, one write or one read per
// cycle on separate write and read ports, so the block never waits on memory
// synchronous active-low reset clears the counters, geometry and output valid;
// the row store has no clearing pass, since every entry is written before use
// in_stall only rises for an item that completes a block while the output
// register is full and stalled; other items keep flowing
// cfg_ready is always high; a geometry write restarts the frame
module image_halve_2x2_avg_or_max (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // source pixels
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [imghalve_pkg::PIX_W-1:0]       in_chan_r,
  input  logic [imghalve_pkg::PIX_W-1:0]       in_chan_g,
  input  logic [imghalve_pkg::PIX_W-1:0]       in_chan_b,
  input  logic [imghalve_pkg::PIX_W-1:0]       in_chan_a,
  // reduced pixels
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [imghalve_pkg::PIX_W-1:0]       out_res_r,
  output logic [imghalve_pkg::PIX_W-1:0]       out_res_g,
  output logic [imghalve_pkg::PIX_W-1:0]       out_res_b,
  output logic [imghalve_pkg::PIX_W-1:0]       out_res_a,
  output logic                                 out_row_end,
  output logic                                 out_frame_end,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [imghalve_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [imghalve_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import imghalve_pkg::*;

  // mode and geometry registers
  logic                  use_max_r;
  logic                  four_ch_r;
  logic [COL_W-1:0]      wm1_r;        // source width - 1
  logic [COL_W-1:0]      last_col_r;   // last column of the even-width area
  logic [ROW_W-1:0]      hm1_r;        // source height - 1
  logic [ROW_W-1:0]      last_row_r;
  logic [COL_W-1:0]      wm1_nxt;
  logic [COL_W-1:0]      last_col_nxt;
  logic [ROW_W-1:0]      hm1_nxt;
  logic [ROW_W-1:0]      last_row_nxt;
  logic [WIDTH_W-1:0]    width_cl;
  logic [HEIGHT_W-1:0]   height_cl;

  // raster position
  logic [COL_W-1:0]      col_r;
  logic [ROW_W-1:0]      row_r;
  logic [COL_W-1:0]      col_nxt;
  logic [ROW_W-1:0]      row_nxt;

  // pixel datapath
  logic [PIXEL_W-1:0]    pix;
  logic [PIXEL_W-1:0]    hold_r;       // even-column pixel of the current pair
  logic [PAIR_W-1:0]     pair_rdata;
  logic [PIXEL_W-1:0]    p00;
  logic [PIXEL_W-1:0]    p01;

  logic                  cfg_wr;
  logic                  in_fire;
  logic                  odd_row;
  logic                  odd_col;
  logic                  res_pos;
  logic                  res_fire;
  logic                  store_we;
  logic                  store_re;
  logic [PAIR_AW-1:0]    pair_addr;

  mode_t                 mode;
  pos_flags_t            flags;
  pos_flags_t            out_flags;
  chan_t [NUM_LANES-1:0] lane_res;
  chan_t [NUM_LANES-1:0] out_res;
  logic                  merge_valid;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  assign odd_row  = row_r[0];
  assign odd_col  = col_r[0];
  // this item completes a 2x2 block
  assign res_pos  = odd_row & odd_col;
  assign in_stall = merge_valid & out_stall & res_pos;
  assign in_fire  = in_valid & ~in_stall;
  assign res_fire = in_fire & res_pos;

  assign pix = {in_chan_a, in_chan_b, in_chan_g, in_chan_r};

  // ---------------- configuration ----------------
  always_comb begin
    width_cl  = cfg_data[WIDTH_W-1:0];
    height_cl = cfg_data[HEIGHT_W-1:0];
    if (width_cl < WIDTH_W'(2)) begin
      width_cl = WIDTH_W'(2);
    end else if (width_cl > WIDTH_W'(MAX_ROW_PIXELS)) begin
      width_cl = WIDTH_W'(MAX_ROW_PIXELS);
    end
    if (height_cl < HEIGHT_W'(2)) begin
      height_cl = HEIGHT_W'(2);
    end else if (height_cl > HEIGHT_W'(MAX_ROWS)) begin
      height_cl = HEIGHT_W'(MAX_ROWS);
    end
    wm1_nxt      = COL_W'(width_cl - WIDTH_W'(1));
    last_col_nxt = COL_W'({width_cl[WIDTH_W-1:1], 1'b0} - WIDTH_W'(1));
    hm1_nxt      = ROW_W'(height_cl - HEIGHT_W'(1));
    last_row_nxt = ROW_W'({height_cl[HEIGHT_W-1:1], 1'b0} - HEIGHT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_max_r  <= 1'b0;
      four_ch_r  <= 1'b0;
      wm1_r      <= COL_W'(1023);
      last_col_r <= COL_W'(1023);
      hm1_r      <= ROW_W'(1023);
      last_row_r <= ROW_W'(1023);
    end else if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_USE_MAXIMUM:   use_max_r <= cfg_data[0];
        CFG_FOUR_CHANNEL:  four_ch_r <= cfg_data[0];
        CFG_SOURCE_WIDTH: begin
          wm1_r      <= wm1_nxt;
          last_col_r <= last_col_nxt;
        end
        CFG_SOURCE_HEIGHT: begin
          hm1_r      <= hm1_nxt;
          last_row_r <= last_row_nxt;
        end
        default: ;
      endcase
    end
  end

  // ---------------- raster counters ----------------
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr && (cfg_idx_t'(cfg_index) == CFG_SOURCE_WIDTH ||
                   cfg_idx_t'(cfg_index) == CFG_SOURCE_HEIGHT)) begin
      // geometry change restarts the frame
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire) begin
      if (col_r == wm1_r) begin
        col_nxt = '0;
        row_nxt = (row_r == hm1_r) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- row store ----------------
  // even rows: pair written on the odd column; odd rows: pair read on the
  // even column and held in the read register until the odd column arrives
  always_ff @(posedge clk) begin
    if (in_fire && !odd_col) begin
      hold_r <= pix;
    end
  end

  assign pair_addr = col_r[COL_W-1:1];
  assign store_we  = in_fire & ~odd_row & odd_col;
  assign store_re  = in_fire & odd_row & ~odd_col;

  imghalve_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (PAIR_DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (pair_addr),
    .wdata ({pix, hold_r}),
    .re    (store_re),
    .raddr (pair_addr),
    .rdata (pair_rdata)
  );

  assign p00 = pair_rdata[PIXEL_W-1:0];
  assign p01 = pair_rdata[PAIR_W-1:PIXEL_W];

  // ---------------- channel lanes ----------------
  assign mode.use_max = use_max_r;
  assign mode.four_ch = four_ch_r;

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    imghalve_lane u_lane (
      .p00  (p00[k*PIX_W +: PIX_W]),
      .p01  (p01[k*PIX_W +: PIX_W]),
      .p10  (hold_r[k*PIX_W +: PIX_W]),
      .p11  (pix[k*PIX_W +: PIX_W]),
      .mode (mode),
      .res  (lane_res[k])
    );
  end

  assign flags.row_end   = (col_r == last_col_r);
  assign flags.frame_end = (col_r == last_col_r) && (row_r == last_row_r);

  // ---------------- merge and output register ----------------
  imghalve_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_fire),
    .lane_res  (lane_res),
    .four_ch   (four_ch_r),
    .flags     (flags),
    .out_stall (out_stall),
    .out_valid (merge_valid),
    .res       (out_res),
    .res_flags (out_flags)
  );

  assign out_valid     = merge_valid;
  assign out_res_r     = out_res[0];
  assign out_res_g     = out_res[1];
  assign out_res_b     = out_res[2];
  assign out_res_a     = out_res[3];
  assign out_row_end   = out_flags.row_end;
  assign out_frame_end = out_flags.frame_end;

endmodule

@@ rtl/core/imghalve_checker.sv @@
// port-level checks for the 2x2 image halving block, bound to the top level
// depends on imghalve_pkg and image_halve_2x2_avg_or_max
module imghalve_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [imghalve_pkg::PIX_W-1:0]       out_res_r,
  input logic                                 out_row_end,
  input logic                                 out_frame_end
);
  import imghalve_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res_r) &&
                               $stable(out_frame_end))
    else $error("stalled result changed");

  // the last pixel of the frame is also the last of its row
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_frame_end || out_row_end)
    else $error("frame end without row end");

  // a new result only follows an accepted item
  a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without accepted item");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind image_halve_2x2_avg_or_max imghalve_checker u_imghalve_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_res_r     (out_res_r),
  .out_row_end   (out_row_end),
  .out_frame_end (out_frame_end)
);

@@ tb/sv/image_halve_2x2_avg_or_max_checker.sv @@
// checker for the 2x2 image halving block: predicts reduced pixels and compares them
// watches the in_, out_ and cfg_ channels; depends on imghalve_pkg
`timescale 1ns / 1ps

module image_halve_2x2_avg_or_max_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  imghalve_pkg::chan_t                 in_chan_r,
  input  imghalve_pkg::chan_t                 in_chan_g,
  input  imghalve_pkg::chan_t                 in_chan_b,
  input  imghalve_pkg::chan_t                 in_chan_a,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  imghalve_pkg::chan_t                 out_res_r,
  input  imghalve_pkg::chan_t                 out_res_g,
  input  imghalve_pkg::chan_t                 out_res_b,
  input  imghalve_pkg::chan_t                 out_res_a,
  input  logic                                out_row_end,
  input  logic                                out_frame_end,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [imghalve_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [imghalve_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                  mismatch_count,
  output int                                  reduced_due_count
);
  import imghalve_pkg::*;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
    chan_t a;
    logic  row_end;
    logic  frame_end;
  } reduced_px_t;

  // mirror of the block state
  logic [PIXEL_W-1:0]  even_rows [MAX_ROW_PIXELS];
  logic [PIXEL_W-1:0]  held_px;
  int                  col_pos;
  int                  row_pos;
  logic                max_mode;
  logic                rgba_mode;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  reduced_px_t         reduced_due [$];

  initial begin
    mismatch_count = 0;
    reduced_due_count = 0;
  end

  // one source pixel through the halving rule; returns 1 when a block completes
  function automatic bit reduce_block(input logic [PIXEL_W-1:0] px, output reduced_px_t res);
    int w, h, col, row, nch, k, a, b, c, d, top, bot;
    logic [PIXEL_W-1:0] p00, p01;
    chan_t lanes [NUM_LANES];
    bit done;
    w = (width_reg < 2) ? 2 : (width_reg > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : int'(width_reg);
    h = (height_reg < 2) ? 2 : (height_reg > MAX_ROWS) ? MAX_ROWS : int'(height_reg);
    col = (col_pos >= w) ? 0 : col_pos;
    row = (row_pos >= h) ? 0 : row_pos;
    done = 1'b0;
    res = '0;
    if (row % 2 == 0) begin
      even_rows[col] = px;
    end else if (col % 2 == 0) begin
      held_px = px;
    end else begin
      p00 = even_rows[col - 1];
      p01 = even_rows[col];
      nch = rgba_mode ? NUM_LANES : 1;
      for (k = 0; k < NUM_LANES; k++) lanes[k] = '0;
      for (k = 0; k < nch; k++) begin
        a = p00[PIX_W*k +: PIX_W];
        b = p01[PIX_W*k +: PIX_W];
        c = held_px[PIX_W*k +: PIX_W];
        d = px[PIX_W*k +: PIX_W];
        if (max_mode) begin
          top = (a > b) ? a : b;
          bot = (c > d) ? c : d;
          lanes[k] = chan_t'((top > bot) ? top : bot);
        end else if (rgba_mode) begin
          top = (a + b + 1) >> 1;
          bot = (c + d + 1) >> 1;
          lanes[k] = chan_t'((top + bot + 1) >> 1);
        end else begin
          lanes[k] = chan_t'((a + b + c + d + 2) >> 2);
        end
      end
      res.r = lanes[0];
      res.g = lanes[1];
      res.b = lanes[2];
      res.a = lanes[3];
      res.row_end = (col == (w & ~1) - 1);
      res.frame_end = res.row_end && (row == (h & ~1) - 1);
      done = 1'b1;
    end
    if (col + 1 >= w) begin
      col = 0;
      row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col++;
    end
    col_pos = col;
    row_pos = row;
    return done;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    reduced_px_t want, fresh;
    if (!rst_n) begin
      max_mode = 1'b0;
      rgba_mode = 1'b0;
      width_reg = WIDTH_W'(1024);
      height_reg = HEIGHT_W'(1024);
      col_pos = 0;
      row_pos = 0;
      reduced_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reduced_due.size() == 0) begin
          $error("reduced pixel out with none expected");
          mismatch_count++;
        end else begin
          want = reduced_due.pop_front();
          check_field("res_r", want.r, out_res_r);
          check_field("res_g", want.g, out_res_g);
          check_field("res_b", want.b, out_res_b);
          check_field("res_a", want.a, out_res_a);
          check_field("row_end", want.row_end, out_row_end);
          check_field("frame_end", want.frame_end, out_frame_end);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_USE_MAXIMUM:  max_mode = cfg_data[0];
          CFG_FOUR_CHANNEL: rgba_mode = cfg_data[0];
          CFG_SOURCE_WIDTH: begin
            width_reg = cfg_data[WIDTH_W-1:0];
            col_pos = 0;
            row_pos = 0;
          end
          CFG_SOURCE_HEIGHT: begin
            height_reg = cfg_data[HEIGHT_W-1:0];
            col_pos = 0;
            row_pos = 0;
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (reduce_block({in_chan_a, in_chan_b, in_chan_g, in_chan_r}, fresh))
          reduced_due.push_back(fresh);
      end
    end
    reduced_due_count <= reduced_due.size();
  end

endmodule

@@ tb/sv/image_halve_2x2_avg_or_max_test.sv @@
// top of the testbench for the 2x2 image halving block: stimulus and verdict
// depends on imghalve_pkg, image_halve_2x2_avg_or_max and the checker module
`timescale 1ns / 1ps

module image_halve_2x2_avg_or_max_test;
  import imghalve_pkg::*;

  localparam int DIRECTED_ITEMS = 57;
  localparam int RANDOM_ITEMS   = 430;
  // receiver hold-off length in cycles
  localparam int SQUEEZE_LEN    = 400;
  // watchdog limit in cycles, sized for the worst-case item count plus config traffic
  localparam int CYCLE_LIMIT    = 800000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  chan_t                 in_chan_r, in_chan_g, in_chan_b, in_chan_a;
  logic                  out_valid;
  logic                  out_stall;
  chan_t                 out_res_r, out_res_g, out_res_b, out_res_a;
  logic                  out_row_end;
  logic                  out_frame_end;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatch_count;
  int reduced_due_count;
  int items_sent = 0;
  int cycle_count;
  bit steady_tx = 1'b0;
  // sender asks for the long hold-off, receiver reports it has started
  bit squeeze_req = 1'b0;
  bit squeeze_on = 1'b0;
  // effective frame size after clamping, used to size the phases
  int frame_w;
  int frame_h;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  image_halve_2x2_avg_or_max dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_chan_r     (in_chan_r),
    .in_chan_g     (in_chan_g),
    .in_chan_b     (in_chan_b),
    .in_chan_a     (in_chan_a),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res_r     (out_res_r),
    .out_res_g     (out_res_g),
    .out_res_b     (out_res_b),
    .out_res_a     (out_res_a),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  image_halve_2x2_avg_or_max_checker halve_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_chan_r         (in_chan_r),
    .in_chan_g         (in_chan_g),
    .in_chan_b         (in_chan_b),
    .in_chan_a         (in_chan_a),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_res_r         (out_res_r),
    .out_res_g         (out_res_g),
    .out_res_b         (out_res_b),
    .out_res_a         (out_res_a),
    .out_row_end       (out_row_end),
    .out_frame_end     (out_frame_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .reduced_due_count (reduced_due_count)
  );

  // idle length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random pixel with extra weight on 0x00 and 0xff per channel
  function automatic logic [PIXEL_W-1:0] random_pixel();
    logic [PIXEL_W-1:0] px;
    int k, pick;
    for (k = 0; k < NUM_LANES; k++) begin
      pick = $urandom_range(0, 9);
      px[PIX_W*k +: PIX_W] = (pick == 0) ? 8'h00 :
                             (pick == 1) ? 8'hff : 8'($urandom_range(0, 255));
    end
    return px;
  endfunction

  // row or column count for small random frames, sometimes below the clamp
  function automatic int pick_extent(input int hi);
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1);
    return $urandom_range(2, hi);
  endfunction

  // one source pixel, packed as a | b | g | r from msb down
  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    int gap;
    gap = steady_tx ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_chan_r <= px[7:0];
    in_chan_g <= px[15:8];
    in_chan_b <= px[23:16];
    in_chan_a <= px[31:24];
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // drop valid, wait for every expected pixel, then wait out items still in
  // flight that make no result
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (reduced_due_count != 0);
    repeat (4) @(posedge clk);
  endtask

  // the closing wait with cfg_valid low keeps back-to-back writes from touching cfg_valid twice
  task automatic write_reg(input cfg_idx_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mode bits carry junk above bit 0, which the block must ignore
  task automatic set_mode(input bit use_max, input bit rgba);
    write_reg(CFG_USE_MAXIMUM, ($urandom_range(0, 4095) << 1) | use_max);
    write_reg(CFG_FOUR_CHANNEL, ($urandom_range(0, 4095) << 1) | rgba);
  endtask

  // geometry write restarts the frame; width gets junk above its 11 bits
  task automatic set_geometry(input int w, input int h);
    write_reg(CFG_SOURCE_WIDTH, w | ($urandom_range(0, 3) << WIDTH_W));
    write_reg(CFG_SOURCE_HEIGHT, h);
    frame_w = (w < 2) ? 2 : (w > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : w;
    frame_h = (h < 2) ? 2 : (h > MAX_ROWS) ? MAX_ROWS : h;
  endtask

  // receiver: random stall stretches, a quiet window, and one long hold-off
  // so the output register fills and in_stall has to rise
  initial begin : receiver
    int hold;
    bit squeezed;
    squeezed = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = (items_sent >= 100 && items_sent < 200) ? 0 : idle_len();
      if (!squeezed && squeeze_req) begin
        squeezed = 1'b1;
        squeeze_on = 1'b1;
        hold = SQUEEZE_LEN;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("image_halve_2x2_avg_or_max test failed");
    $finish;
  end

  initial begin : stimulus
    int n;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_chan_r <= '0;
    in_chan_g <= '0;
    in_chan_b <= '0;
    in_chan_a <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_USE_MAXIMUM;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // grayscale average, 4x2: all-255 block, then a block whose sum rounds up;
    // g, b and a carry junk that must not leak into the result
    set_mode(1'b0, 1'b0);
    set_geometry(4, 2);
    send_pixel(32'h5a3c_96ff);
    send_pixel(32'ha5c3_69ff);
    send_pixel(32'h0102_0300);
    send_pixel(32'hffff_ff01);
    send_pixel(32'h0000_00ff);
    send_pixel(32'h7e7e_7eff);
    send_pixel(32'hc0de_0001);
    send_pixel(32'h1234_5600);
    settle();

    // rgba average, 2x2: pairwise rounding with 0x00 and 0xff on every lane
    set_mode(1'b0, 1'b1);
    set_geometry(2, 2);
    send_pixel(32'hff00_01fe);
    send_pixel(32'h00ff_00ff);
    send_pixel(32'hff01_ff00);
    send_pixel(32'h0000_ffff);
    settle();

    // rgba maximum, no geometry write: frame carries on, mode acts at once
    write_reg(CFG_USE_MAXIMUM, 1);
    send_pixel(32'h807f_ff01);
    send_pixel(32'h7f80_00fe);
    send_pixel(32'h0100_7f80);
    send_pixel(32'hfeff_8000);
    settle();

    // grayscale maximum, 3x3: odd last column and odd last row are dropped
    write_reg(CFG_FOUR_CHANNEL, 0);
    set_geometry(3, 3);
    repeat (9) send_pixel(random_pixel());
    settle();

    // two 4x4 frames streamed while the receiver holds off for a long stretch
    set_geometry(4, 4);
    steady_tx = 1'b1;
    squeeze_req = 1'b1;
    wait (squeeze_on);
    repeat (32) send_pixel(random_pixel());
    settle();
    steady_tx = 1'b0;

    // random phases on small frames, whole frames plus sometimes a partial one
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      steady_tx = ($urandom_range(0, 3) == 0);
      set_mode($urandom_range(0, 1), $urandom_range(0, 1));
      if ($urandom_range(0, 3) != 0)
        set_geometry(pick_extent(9), pick_extent(7));
      n = $urandom_range(1, 2) * frame_w * frame_h;
      if ($urandom_range(0, 2) == 0)
        n += $urandom_range(1, frame_w * frame_h - 1);
      repeat (n) send_pixel(random_pixel());
      settle();
    end
    steady_tx = 1'b0;

    // tallest frame, clamped from above and exact, with the narrowest rows
    set_geometry(1, 8191);
    repeat (12) send_pixel(random_pixel());
    settle();
    set_geometry(0, 4096);
    repeat (10) send_pixel(random_pixel());
    settle();

    if (mismatch_count == 0) begin
      $display("image_halve_2x2_avg_or_max test passed");
    end else begin
      $display("image_halve_2x2_avg_or_max test failed");
    end
    $finish;
  end

endmodule
